/* rtl/dhz_pkg.sv */
// shared types, constants, divider steps and min3 for the dehaze pixel recovery core
package dhz_pkg;

  localparam int NUM_STAGES = 12;

  localparam logic [15:0] VEIL_GAIN_RST       = 16'd0;
  localparam logic [7:0]  AIR_LIGHT_RST       = 8'd255;
  localparam logic [7:0]  BLEND_THRESHOLD_RST = 8'd60;

  typedef enum logic [1:0] {
    REG_VEIL_GAIN       = 2'd0,
    REG_AIR_LIGHT       = 2'd1,
    REG_BLEND_THRESHOLD = 2'd2
  } reg_idx_t;

  // partial remainder and dividend/quotient shift word of an 8-bit restoring divider
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] dvd;
  } div_t;

  function automatic div_t div_step(div_t s, logic [7:0] den);
    logic [8:0] rem9;
    logic       qb;
    div_t       o;
    rem9 = {s.rem, s.dvd[7]};
    qb   = (rem9 >= {1'b0, den});
    if (qb) begin
      o.rem = 8'(rem9 - {1'b0, den});
    end else begin
      o.rem = rem9[7:0];
    end
    o.dvd = {s.dvd[6:0], qb};
    return o;
  endfunction

  function automatic div_t div_two(div_t s, logic [7:0] den);
    return div_step(div_step(s, den), den);
  endfunction

  function automatic logic [7:0] min3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [7:0] m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

endpackage

/* rtl/dehaze_pixel_recovery_core.sv */
// dehaze pixel recovery core: veil, haze inversion and dark-pixel blend, 12-stage pipeline
//
// pixel channel: pixel_valid / pixel_stall with in_red, in_green, in_blue, dark_value and
// mean_dark. an item is taken on a clock edge where pixel_valid is high and pixel_stall low.
// result channel: result_valid / result_stall with out_red, out_green, out_blue, one result
// per pixel, in order.
// config channel: cfg_valid / cfg_ready with cfg_index (0 veil_gain, 1 air_light,
// 2 blend_threshold) and cfg_data; cfg_ready is always high, other indexes are ignored.
// write registers only while the pipeline is empty.
// a pixel passes through stages 1 to 12 before result_valid rises for it; one pixel per cycle
// is sustained while result_stall stays low.
// the stages hold two 8-bit restoring dividers (haze inversion by |A - veil| and blend by
// the threshold), each retiring two quotient bits per stage, plus veil, min and multiply stages.
// a stalled result holds in the output register; upstream stages keep advancing into empty
// slots, so pixel_stall rises only once every stage holds an item.
// synchronous reset empties the pipeline and loads veil_gain 0, air_light 255,
// blend_threshold 60.
module dehaze_pixel_recovery_core
  import dhz_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  dark_value,
  input  logic [7:0]  mean_dark,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] veil_gain;
  logic [7:0]  air_light;
  logic [7:0]  blend_threshold;

  logic [NUM_STAGES:1] vld;
  logic [NUM_STAGES:1] adv;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      veil_gain       <= VEIL_GAIN_RST;
      air_light       <= AIR_LIGHT_RST;
      blend_threshold <= BLEND_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_VEIL_GAIN:       veil_gain       <= cfg_data;
        REG_AIR_LIGHT:       air_light       <= cfg_data[7:0];
        REG_BLEND_THRESHOLD: blend_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // stage advance: a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NUM_STAGES] = !vld[NUM_STAGES] || !result_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k + 1];
    end
  end

  assign pixel_stall  = !adv[1];
  assign result_valid = vld[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= pixel_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k - 1];
        end
      end
    end
  end

  // stage 1: scaled mean
  logic [7:0]  s1_c [3];
  logic [7:0]  s1_d;
  logic [7:0]  s1_scaled;
  logic [23:0] gain_prod;

  assign gain_prod = {8'd0, veil_gain} * {16'd0, mean_dark};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_c[0]   <= in_red;
      s1_c[1]   <= in_green;
      s1_c[2]   <= in_blue;
      s1_d      <= dark_value;
      s1_scaled <= gain_prod[23:16];
    end
  end

  // stage 2: veil, sign of the quotient, magnitude of numerator and denominator
  logic [7:0]  veil;
  logic        a_eq;
  logic        a_gt;
  logic [7:0]  den_c;
  logic [15:0] num_c  [3];
  logic        zero_c [3];
  logic        sat_c  [3];

  logic [7:0]  s2_c    [3];
  logic [15:0] s2_num  [3];
  logic        s2_zero [3];
  logic        s2_sat  [3];
  logic [7:0]  s2_den;

  always_comb begin
    logic       gt;
    logic       lt;
    logic [7:0] diff;
    veil  = (s1_scaled < s1_d) ? s1_scaled : s1_d;
    a_eq  = (air_light == veil);
    a_gt  = (air_light > veil);
    den_c = a_gt ? 8'(air_light - veil) : 8'(veil - air_light);
    for (int k = 0; k < 3; k++) begin
      gt        = (s1_c[k] > veil);
      lt        = (s1_c[k] < veil);
      diff      = gt ? 8'(s1_c[k] - veil) : 8'(veil - s1_c[k]);
      num_c[k]  = {8'd0, diff} * {8'd0, air_light};
      // equal air light and veil: hard step at the veil
      zero_c[k] = a_eq ? !gt : !((gt && a_gt) || (lt && !a_gt));
      sat_c[k]  = a_eq && gt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_den <= den_c;
      for (int k = 0; k < 3; k++) begin
        s2_c[k]    <= s1_c[k];
        s2_num[k]  <= num_c[k];
        s2_zero[k] <= zero_c[k];
        s2_sat[k]  <= sat_c[k];
      end
    end
  end

  // stages 3 to 6: recovery divider, two quotient bits per stage
  logic [7:0] s3_c [3], s4_c [3], s5_c [3], s6_c [3];
  div_t       s3_div [3], s4_div [3], s5_div [3], s6_div [3];
  logic       s3_zero [3], s4_zero [3], s5_zero [3], s6_zero [3];
  logic       s3_sat [3], s4_sat [3], s5_sat [3], s6_sat [3];
  logic [7:0] s3_den, s4_den, s5_den;

  always_ff @(posedge clk) begin
    div_t init;
    if (adv[3]) begin
      s3_den <= s2_den;
      for (int k = 0; k < 3; k++) begin
        init.rem   = s2_num[k][15:8];
        init.dvd   = s2_num[k][7:0];
        s3_div[k]  <= div_two(init, s2_den);
        s3_zero[k] <= s2_zero[k];
        // quotient above 255 saturates
        s3_sat[k]  <= s2_sat[k] || (s2_num[k][15:8] >= s2_den);
        s3_c[k]    <= s2_c[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_den <= s3_den;
      for (int k = 0; k < 3; k++) begin
        s4_div[k]  <= div_two(s3_div[k], s3_den);
        s4_zero[k] <= s3_zero[k];
        s4_sat[k]  <= s3_sat[k];
        s4_c[k]    <= s3_c[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_den <= s4_den;
      for (int k = 0; k < 3; k++) begin
        s5_div[k]  <= div_two(s4_div[k], s4_den);
        s5_zero[k] <= s4_zero[k];
        s5_sat[k]  <= s4_sat[k];
        s5_c[k]    <= s4_c[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int k = 0; k < 3; k++) begin
        s6_div[k]  <= div_two(s5_div[k], s5_den);
        s6_zero[k] <= s5_zero[k];
        s6_sat[k]  <= s5_sat[k];
        s6_c[k]    <= s5_c[k];
      end
    end
  end

  // stage 7: clamp, minimum of recovered channels, blend decision
  logic [7:0] rec_c [3];
  logic [7:0] rmin_c;

  logic [7:0] s7_c [3];
  logic [7:0] s7_r [3];
  logic [7:0] s7_m;
  logic [7:0] s7_tm;
  logic       s7_blend;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s6_zero[k]) begin
        rec_c[k] = 8'd0;
      end else if (s6_sat[k]) begin
        rec_c[k] = 8'd255;
      end else begin
        rec_c[k] = s6_div[k].dvd;
      end
    end
    rmin_c = min3(rec_c[0], rec_c[1], rec_c[2]);
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_m     <= rmin_c;
      s7_tm    <= 8'(blend_threshold - rmin_c);
      s7_blend <= (rmin_c < blend_threshold);
      for (int k = 0; k < 3; k++) begin
        s7_c[k] <= s6_c[k];
        s7_r[k] <= rec_c[k];
      end
    end
  end

  // stage 8: blend numerator c*(T-m) + r*m
  logic [15:0] s8_num [3];
  logic [7:0]  s8_r   [3];
  logic        s8_blend;

  always_ff @(posedge clk) begin
    logic [15:0] pc;
    logic [15:0] pr;
    if (adv[8]) begin
      s8_blend <= s7_blend;
      for (int k = 0; k < 3; k++) begin
        pc        = {8'd0, s7_c[k]} * {8'd0, s7_tm};
        pr        = {8'd0, s7_r[k]} * {8'd0, s7_m};
        s8_num[k] <= pc + pr;
        s8_r[k]   <= s7_r[k];
      end
    end
  end

  // stages 9 to 12: blend divider by the threshold
  div_t       s9_div [3], s10_div [3], s11_div [3];
  logic [7:0] s9_r [3], s10_r [3], s11_r [3];
  logic       s9_blend, s10_blend, s11_blend;
  logic [7:0] res [3];

  always_ff @(posedge clk) begin
    div_t init;
    if (adv[9]) begin
      s9_blend <= s8_blend;
      for (int k = 0; k < 3; k++) begin
        init.rem  = s8_num[k][15:8];
        init.dvd  = s8_num[k][7:0];
        s9_div[k] <= div_two(init, blend_threshold);
        s9_r[k]   <= s8_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      s10_blend <= s9_blend;
      for (int k = 0; k < 3; k++) begin
        s10_div[k] <= div_two(s9_div[k], blend_threshold);
        s10_r[k]   <= s9_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      s11_blend <= s10_blend;
      for (int k = 0; k < 3; k++) begin
        s11_div[k] <= div_two(s10_div[k], blend_threshold);
        s11_r[k]   <= s10_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    div_t fin;
    if (adv[12]) begin
      for (int k = 0; k < 3; k++) begin
        fin    = div_two(s11_div[k], blend_threshold);
        res[k] <= s11_blend ? fin.dvd : s11_r[k];
      end
    end
  end

  assign out_red   = res[0];
  assign out_green = res[1];
  assign out_blue  = res[2];

`ifndef NO_ASSERTIONS
  // reset empties every stage
  a_reset_empty: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  // the input only stalls when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> ((&vld) && result_stall))
    else $error("input stalled with room in the pipeline");

  // recovery divider remainder stays below the divisor unless the result is forced
  a_rec_rem: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> ((s3_zero[0] || s3_sat[0] || (s3_div[0].rem < s3_den)) &&
                (s3_zero[1] || s3_sat[1] || (s3_div[1].rem < s3_den)) &&
                (s3_zero[2] || s3_sat[2] || (s3_div[2].rem < s3_den))))
    else $error("recovery divider remainder out of range");

  // blend quotient fits eight bits
  a_blend_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[9] && s9_blend) |-> ((s9_div[0].rem < blend_threshold) &&
                              (s9_div[1].rem < blend_threshold) &&
                              (s9_div[2].rem < blend_threshold)))
    else $error("blend divider remainder out of range");
`endif

endmodule

/* bench/dehaze_pixel_recovery_checker.sv */
// checker for the dehaze pixel recovery core: predicts each result and compares it
`timescale 1ns / 1ps

module dehaze_pixel_recovery_checker
  import dhz_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  input  logic        pixel_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  dark_value,
  input  logic [7:0]  mean_dark,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          results_pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic [15:0] gain_q;
  logic [7:0]  air_q;
  logic [7:0]  thr_q;
  rgb_t        expected_pixels[$];

  // undo the haze model for one channel against the air light
  function automatic logic [7:0] recover_level(logic [7:0] c, logic [7:0] v, logic [7:0] a);
    int num;
    int den;
    int q;
    if (a == v) begin
      return (c > v) ? 8'd255 : 8'd0;
    end
    num = (int'(c) - int'(v)) * int'(a);
    den = int'(a) - int'(v);
    // signed division truncates toward zero, denominator may be negative
    q = num / den;
    if (q < 0) begin
      return 8'd0;
    end
    if (q > 255) begin
      return 8'd255;
    end
    return 8'(q);
  endfunction

  function automatic rgb_t dehaze_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                                        logic [7:0] dark, logic [7:0] mean);
    logic [7:0]  chan [3];
    logic [7:0]  rec [3];
    logic [7:0]  outc [3];
    logic [23:0] scaled;
    logic [7:0]  veil;
    logic [7:0]  m;
    int          blend;
    int          k;
    chan[0] = red;
    chan[1] = green;
    chan[2] = blue;
    scaled = (24'(gain_q) * 24'(mean)) >> 16;
    veil = (scaled[7:0] < dark) ? scaled[7:0] : dark;
    for (k = 0; k < 3; k++) begin
      rec[k] = recover_level(chan[k], veil, air_q);
    end
    m = rec[0];
    if (rec[1] < m) m = rec[1];
    if (rec[2] < m) m = rec[2];
    for (k = 0; k < 3; k++) begin
      if (m < thr_q) begin
        // dark pixel: pull back toward the hazy input
        blend = (int'(chan[k]) * (int'(thr_q) - int'(m)) + int'(rec[k]) * int'(m)) /
                int'(thr_q);
        outc[k] = 8'(blend);
      end else begin
        outc[k] = rec[k];
      end
    end
    return '{red: outc[0], green: outc[1], blue: outc[2]};
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      gain_q <= VEIL_GAIN_RST;
      air_q  <= AIR_LIGHT_RST;
      thr_q  <= BLEND_THRESHOLD_RST;
      expected_pixels.delete();
    end else begin
      // retire before taking the new item so a same-edge pair never pairs up
      if (result_valid && !result_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %0d %0d %0d with nothing expected",
                                    out_red, out_green, out_blue));
        end else begin
          want = expected_pixels.pop_front();
          if (out_red !== want.red)
            report_mismatch($sformatf("out_red %0d, expected %0d", out_red, want.red));
          if (out_green !== want.green)
            report_mismatch($sformatf("out_green %0d, expected %0d", out_green, want.green));
          if (out_blue !== want.blue)
            report_mismatch($sformatf("out_blue %0d, expected %0d", out_blue, want.blue));
        end
      end
      if (pixel_valid && !pixel_stall) begin
        expected_pixels.push_back(dehaze_pixel(in_red, in_green, in_blue,
                                               dark_value, mean_dark));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VEIL_GAIN:       gain_q <= cfg_data;
          REG_AIR_LIGHT:       air_q  <= cfg_data[7:0];
          REG_BLEND_THRESHOLD: thr_q  <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
    results_pending <= expected_pixels.size();
  end

endmodule

/* bench/dehaze_pixel_recovery_core_tb.sv */
// testbench top for the dehaze pixel recovery core: stimulus, config phases and verdict
`timescale 1ns / 1ps

module dehaze_pixel_recovery_core_tb;
  import dhz_pkg::*;

  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         NUM_PHASES  = 8;
  localparam int         PHASE_ITEMS = 92;

  logic        clk;
  logic        rst;
  logic        pixel_valid;
  logic        pixel_stall;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic [7:0]  dark_value;
  logic [7:0]  mean_dark;
  logic        result_valid;
  logic        result_stall;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int          mismatch_count;
  int          results_pending;
  int          cycle_count = 0;
  int          idle_pct;
  int          stall_pct;
  logic [7:0]  cur_air;

  dehaze_pixel_recovery_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .dark_value   (dark_value),
    .mean_dark    (mean_dark),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dehaze_pixel_recovery_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .pixel_valid     (pixel_valid),
    .pixel_stall     (pixel_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .dark_value      (dark_value),
    .mean_dark       (mean_dark),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL dehaze_pixel_recovery_core");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // starts and ends on a falling edge; valid stays high after the item is taken
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] d, logic [7:0] m);
    while ($urandom_range(99) < idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    in_red      <= r;
    in_green    <= g;
    in_blue     <= b;
    dark_value  <= d;
    mean_dark   <= m;
    do @(posedge clk); while (!(pixel_valid && !pixel_stall));
    @(negedge clk);
  endtask

  task automatic drain_results();
    pixel_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] gain, logic [7:0] air, logic [7:0] thr);
    drain_results();
    write_reg(REG_VEIL_GAIN, gain);
    write_reg(REG_AIR_LIGHT, {8'($urandom_range(255)), air});
    write_reg(REG_BLEND_THRESHOLD, {8'($urandom_range(255)), thr});
    // spare index must be ignored
    write_reg(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    cur_air = air;
  endtask

  function automatic int rand_level(int top);
    case ($urandom_range(3))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(top);
    endcase
  endfunction

  task automatic send_random_pixel();
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] d;
    logic [7:0] m;
    logic [7:0] lo;
    int         pick;
    int         jitter;
    r = 8'($urandom_range(255));
    g = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 70) begin
      // natural pixel: dark value at or below the smallest channel, mean close to it
      lo = (r < g) ? r : g;
      lo = (b < lo) ? b : lo;
      d = 8'($urandom_range(lo));
      jitter = int'(d) + int'($urandom_range(80)) - 40;
      m = (jitter < 0) ? 8'd0 : (jitter > 255) ? 8'd255 : 8'(jitter);
    end else if (pick < 82) begin
      // aim the veil at the air light
      d = cur_air;
      m = 8'd255;
    end else begin
      d = 8'($urandom_range(255));
      m = 8'($urandom_range(255));
    end
    send_pixel(r, g, b, d, m);
  endtask

  initial begin
    int ph;
    int n;
    rst          = 1'b1;
    pixel_valid  = 1'b0;
    in_red       = 8'd0;
    in_green     = 8'd0;
    in_blue      = 8'd0;
    dark_value   = 8'd0;
    mean_dark    = 8'd0;
    result_stall = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_VEIL_GAIN;
    cfg_data     = 16'd0;
    idle_pct     = 0;
    stall_pct    = 0;
    cur_air      = AIR_LIGHT_RST;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset settings: no veil, recovery is the identity
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd10, 8'd20, 8'd30, 8'd5, 8'd200);

    // threshold zero shows the raw recovery
    set_config(16'hffff, 8'd128, 8'd0);
    send_pixel(8'd200, 8'd128, 8'd50, 8'd128, 8'd255);   // air light equals veil
    send_pixel(8'd255, 8'd0, 8'd129, 8'd200, 8'd255);    // veil above air light
    send_pixel(8'd255, 8'd130, 8'd140, 8'd100, 8'd255);
    send_pixel(8'd90, 8'd100, 8'd110, 8'd100, 8'd50);

    set_config(16'h8000, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd64, 8'd32, 8'd40, 8'd200);
    send_pixel(8'd1, 8'd2, 8'd3, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd128, 8'd255, 8'd255);

    // zero air light
    set_config(16'hffff, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd1, 8'd255, 8'd0, 8'd0);
    send_pixel(8'd50, 8'd60, 8'd70, 8'd30, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd15, 8'd240, 8'd128);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_config(16'hffff, 8'd255, 8'd255);
        1:       set_config(16'd0, 8'd0, 8'd0);
        2:       set_config(16'hffff, 8'd0, 8'd255);
        default: set_config(16'(rand_level(65535)), 8'(rand_level(255)),
                            8'(rand_level(255)));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // once in a while let the pipeline run dry mid-stream
        if (n == PHASE_ITEMS / 2 && ph % 3 == 1) begin
          drain_results();
        end
        send_random_pixel();
      end
    end

    drain_results();
    repeat (NUM_STAGES + 4) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("PASS dehaze_pixel_recovery_core");
    end else begin
      $display("FAIL dehaze_pixel_recovery_core");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dhz_pkg.sv
rtl/dehaze_pixel_recovery_core.sv
bench/dehaze_pixel_recovery_checker.sv
bench/dehaze_pixel_recovery_core_tb.sv
